[design/msm_pkg.sv]
// Shared types, constants and helpers for the motif synchronization matrix.
package msm_pkg;

  localparam int CHANNELS      = 8;
  localparam int MAX_WINDOW    = 64;
  localparam int MAX_LAG       = 16;
  localparam int SAMPLE_BITS   = 16;
  localparam int HISTORY_DEPTH = 128;

  localparam int CH_W     = $clog2(CHANNELS);
  localparam int NCH_W    = 4;
  localparam int WLEN_W   = 7;
  localparam int LAG_W    = 5;
  localparam int CODE_W   = 3;
  localparam int ADDR_W   = $clog2(HISTORY_DEPTH);
  localparam int ROW_W    = CHANNELS * CODE_W;
  localparam int CNT_W    = 7;
  localparam int SEEN_W   = 8;
  localparam int IDX_W    = 32;
  localparam int CFG_AW   = 4;
  localparam int CFG_DW   = 32;
  localparam int IN_DW    = CHANNELS * SAMPLE_BITS;
  localparam int OUT_DW   = 48;

  // register indexes
  localparam logic [1:0] REG_WLEN = 2'd0;
  localparam logic [1:0] REG_LMIN = 2'd1;
  localparam logic [1:0] REG_LMAX = 2'd2;
  localparam logic [1:0] REG_NCH  = 2'd3;

  // motif codes
  localparam logic [CODE_W-1:0] MOTIF_FALL   = 3'd1;
  localparam logic [CODE_W-1:0] MOTIF_VALLEY = 3'd2;
  localparam logic [CODE_W-1:0] MOTIF_PEAK   = 3'd3;
  localparam logic [CODE_W-1:0] MOTIF_RISE   = 3'd4;
  localparam logic [CODE_W-1:0] MOTIF_OTHER  = 3'd5;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [CNT_W-1:0]              cnt_t;
  typedef logic [ADDR_W-1:0]             addr_t;
  typedef logic [ROW_W-1:0]              row_t;
  typedef cnt_t [CHANNELS-1:0][CHANNELS-1:0] pair_cnt_t;

  typedef struct packed {
    logic valid;
    logic first_k;
    logic last_k;
  } lane_ctl_t;

  typedef struct packed {
    logic [WLEN_W-1:0] wlen;
    logic [LAG_W-1:0]  lmin;
    logic [LAG_W-1:0]  lmax;
    logic [NCH_W-1:0]  nch;
  } cfg_t;

  function automatic logic [CODE_W-1:0] motif_code(sample_t a, sample_t b, sample_t c);
    logic [CODE_W-1:0] r;
    if (a > b && b > c)      r = MOTIF_FALL;
    else if (a > b && b < c) r = MOTIF_VALLEY;
    else if (a < b && b > c) r = MOTIF_PEAK;
    else if (a < b && b < c) r = MOTIF_RISE;
    else                     r = MOTIF_OTHER;
    return r;
  endfunction

endpackage

[design/msm_cfg.sv]
// APB-style register block holding the four settings.
module msm_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [msm_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [msm_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [msm_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                          cfg_pready,
  output msm_pkg::cfg_t                 cfg
);
  import msm_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic       wr;
  logic [1:0] idx;

  assign cfg_pready = 1'b1;
  assign wr  = cfg_psel & cfg_penable & cfg_pwrite;
  assign idx = cfg_paddr[3:2];
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (idx)
        REG_WLEN: cfg_nxt.wlen = cfg_pwdata[WLEN_W-1:0];
        REG_LMIN: cfg_nxt.lmin = cfg_pwdata[LAG_W-1:0];
        REG_LMAX: cfg_nxt.lmax = cfg_pwdata[LAG_W-1:0];
        REG_NCH:  cfg_nxt.nch  = cfg_pwdata[NCH_W-1:0];
        default:  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_WLEN: cfg_prdata = {{(CFG_DW-WLEN_W){1'b0}}, cfg_r.wlen};
      REG_LMIN: cfg_prdata = {{(CFG_DW-LAG_W){1'b0}}, cfg_r.lmin};
      REG_LMAX: cfg_prdata = {{(CFG_DW-LAG_W){1'b0}}, cfg_r.lmax};
      REG_NCH:  cfg_prdata = {{(CFG_DW-NCH_W){1'b0}}, cfg_r.nch};
      default:  cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wlen <= WLEN_W'(16);
      cfg_r.lmin <= '0;
      cfg_r.lmax <= LAG_W'(4);
      cfg_r.nch  <= NCH_W'(8);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[design/msm_hist_ram.sv]
// Motif history memory: one row of codes per time step, one write and two read ports.
module msm_hist_ram (
  input  logic                 clk,
  input  logic                 we,
  input  msm_pkg::addr_t       waddr,
  input  msm_pkg::row_t        wdata,
  input  msm_pkg::addr_t       raddr_p,
  input  msm_pkg::addr_t       raddr_q,
  output msm_pkg::row_t        rdata_p,
  output msm_pkg::row_t        rdata_q
);
  import msm_pkg::*;

  row_t mem [HISTORY_DEPTH];
  row_t rdata_p_r, rdata_q_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_p_r <= mem[raddr_p];
    rdata_q_r <= mem[raddr_q];
  end

  assign rdata_p = rdata_p_r;
  assign rdata_q = rdata_q_r;

endmodule

[design/msm_pair_lanes.sv]
// One lane per channel pair: match counters both ways and running best per pair.
module msm_pair_lanes (
  input  logic                 clk,
  input  logic                 clear_best,
  input  msm_pkg::lane_ctl_t   ctl,
  input  msm_pkg::row_t        row_p,
  input  msm_pkg::row_t        row_q,
  output msm_pkg::pair_cnt_t   best
);
  import msm_pkg::*;

  genvar gi, gj;
  generate
    for (gi = 0; gi < CHANNELS; gi++) begin : g_i
      for (gj = 0; gj < CHANNELS; gj++) begin : g_j
        if (gi < gj) begin : g_lane
          cnt_t xy_r, yx_r, best_r;
          cnt_t xy_nxt, yx_nxt, best_nxt;
          logic eq_xy, eq_yx;

          assign eq_xy = row_p[gi*CODE_W +: CODE_W] == row_q[gj*CODE_W +: CODE_W];
          assign eq_yx = row_p[gj*CODE_W +: CODE_W] == row_q[gi*CODE_W +: CODE_W];

          always_comb begin
            xy_nxt   = (ctl.first_k ? '0 : xy_r) + cnt_t'(eq_xy);
            yx_nxt   = (ctl.first_k ? '0 : yx_r) + cnt_t'(eq_yx);
            best_nxt = best_r;
            if (ctl.last_k) begin
              if (xy_nxt > best_nxt) best_nxt = xy_nxt;
              if (yx_nxt > best_nxt) best_nxt = yx_nxt;
            end
          end

          always_ff @(posedge clk) begin
            if (clear_best) begin
              best_r <= '0;
            end else if (ctl.valid) begin
              xy_r   <= xy_nxt;
              yx_r   <= yx_nxt;
              best_r <= best_nxt;
            end
          end

          assign best[gi][gj] = best_r;
        end else begin : g_none
          assign best[gi][gj] = '0;
        end
      end
    end
  endgenerate

endmodule

[design/motif_synchronization_matrix.sv]
// Motif synchronization matrix top level: motif coding, history, window scan, pair results.
// Operation: a row that completes a window moves IDLE to SCAN, which walks the two-port history
//   memory over lags lag_min..lag_max and window positions (one lag/position per cycle, all 28
//   pairs in parallel), then DRAIN and EMIT, one pair per cycle while out_tready allows. Input
//   is held off until the last pair is loaded; rows that complete no window go back to back.
// Reset (rst_n, synchronous): settings to defaults, sample taps, seen/head/window-index counters
//   and FSM cleared; the history memory is not cleared and is never read before written.
module motif_synchronization_matrix (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata: sample_0 [15:0], sample_1 [31:16], ... sample_7 [127:112]
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [msm_pkg::IN_DW-1:0]      in_tdata,
  // out_tdata: window_index [31:0], first_channel [34:32], second_channel [37:35],
  //            sync_count [44:38], zero fill [47:45]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [msm_pkg::OUT_DW-1:0]     out_tdata,
  output logic                           out_tlast,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [msm_pkg::CFG_AW-1:0]     cfg_paddr,
  input  logic [msm_pkg::CFG_DW-1:0]     cfg_pwdata,
  output logic [msm_pkg::CFG_DW-1:0]     cfg_prdata,
  output logic                           cfg_pready
);
  import msm_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  cfg_t cfg;

  msm_cfg u_cfg (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready, .cfg
  );

  state_t state_r, state_nxt;
  logic   in_fire;
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid & in_tready;

  // --- settings clamped as seen by this row
  logic [LAG_W-1:0]  lmax_c;
  logic [WLEN_W-1:0] w_c;
  logic [NCH_W-1:0]  nch_c;
  logic [SEEN_W-1:0] span, thresh;

  always_comb begin
    lmax_c = (cfg.lmax > LAG_W'(MAX_LAG)) ? LAG_W'(MAX_LAG) : cfg.lmax;
    if (cfg.wlen == '0) w_c = WLEN_W'(1);
    else if (cfg.wlen > WLEN_W'(MAX_WINDOW)) w_c = WLEN_W'(MAX_WINDOW);
    else w_c = cfg.wlen;
    if (cfg.nch < NCH_W'(2)) nch_c = NCH_W'(2);
    else if (cfg.nch > NCH_W'(CHANNELS)) nch_c = NCH_W'(CHANNELS);
    else nch_c = cfg.nch;
    span   = SEEN_W'(w_c) + SEEN_W'(lmax_c);
    thresh = span + SEEN_W'(2);
  end

  // --- sample taps and motif row
  sample_t [CHANNELS-1:0] prev_r, older_r;
  row_t                   motif_row;
  logic   [SEEN_W-1:0]    seen_r, seen_nxt;
  addr_t                  head_r, head_nxt;
  logic   [IDX_W-1:0]     widx_r;
  logic                   hist_we, emit;

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      motif_row[c*CODE_W +: CODE_W] =
        motif_code(older_r[c], prev_r[c], in_tdata[c*SAMPLE_BITS +: SAMPLE_BITS]);
    end
  end

  assign hist_we  = in_fire && (seen_r >= SEEN_W'(2));
  assign head_nxt = hist_we ? head_r + addr_t'(1) : head_r;
  assign seen_nxt = (seen_r < thresh) ? seen_r + SEEN_W'(1) : seen_r;
  assign emit     = seen_nxt >= thresh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      older_r <= '0;
      seen_r  <= '0;
      head_r  <= '0;
    end else if (in_fire) begin
      for (int c = 0; c < CHANNELS; c++) begin
        older_r[c] <= prev_r[c];
        prev_r[c]  <= sample_t'(in_tdata[c*SAMPLE_BITS +: SAMPLE_BITS]);
      end
      seen_r <= seen_nxt;
      head_r <= head_nxt;
    end
  end

  // --- scan working registers (window settings latched on each accepted input beat)
  logic [WLEN_W-1:0] w_r;
  logic [LAG_W-1:0]  lmax_r;
  logic [NCH_W-1:0]  nch_r;
  addr_t             start_r;
  logic [WLEN_W-1:0] k_r, k_nxt;
  logic [LAG_W-1:0]  l_r, l_nxt;
  logic [CH_W-1:0]   pi_r, pi_nxt, pj_r, pj_nxt;
  logic [IDX_W-1:0]  cur_idx_r;
  lane_ctl_t         ctl, ctl_d_r;
  logic              issue, last_k, last_pair, out_load;
  addr_t             raddr_p, raddr_q;
  row_t              row_p, row_q;
  pair_cnt_t         best;

  assign issue   = (state_r == ST_SCAN);
  assign last_k  = (k_r == w_r - WLEN_W'(1));
  assign raddr_p = start_r + addr_t'(k_r);
  assign raddr_q = start_r + addr_t'(k_r) + addr_t'(l_r);
  assign ctl     = '{valid: issue, first_k: issue && (k_r == '0), last_k: issue && last_k};

  msm_hist_ram u_ram (
    .clk, .we(hist_we), .waddr(head_r), .wdata(motif_row),
    .raddr_p, .raddr_q, .rdata_p(row_p), .rdata_q(row_q)
  );

  msm_pair_lanes u_lanes (
    .clk, .clear_best(in_fire), .ctl(ctl_d_r), .row_p, .row_q, .best
  );

  // output beat register
  logic             out_valid_r;
  logic [OUT_DW-1:0] out_data_r;
  logic             out_last_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_load   = (state_r == ST_EMIT) && (!out_valid_r || out_tready);
  assign last_pair  = ({1'b0, pi_r} == nch_r - NCH_W'(2)) &&
                      ({1'b0, pj_r} == nch_r - NCH_W'(1));

  always_comb begin
    state_nxt = state_r;
    k_nxt  = k_r;
    l_nxt  = l_r;
    pi_nxt = pi_r;
    pj_nxt = pj_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && emit) begin
          k_nxt  = '0;
          l_nxt  = cfg.lmin;
          pi_nxt = '0;
          pj_nxt = CH_W'(1);
          state_nxt = (cfg.lmin > lmax_c) ? ST_DRAIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_k) begin
          k_nxt = '0;
          if (l_r == lmax_r) state_nxt = ST_DRAIN;
          else l_nxt = l_r + LAG_W'(1);
        end else begin
          k_nxt = k_r + WLEN_W'(1);
        end
      end
      ST_DRAIN: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_load) begin
          if (last_pair) begin
            state_nxt = ST_IDLE;
          end else if ({1'b0, pj_r} == nch_r - NCH_W'(1)) begin
            pi_nxt = pi_r + CH_W'(1);
            pj_nxt = pi_r + CH_W'(2);
          end else begin
            pj_nxt = pj_r + CH_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ctl_d_r     <= '0;
      out_valid_r <= 1'b0;
      widx_r      <= '0;
    end else begin
      state_r <= state_nxt;
      ctl_d_r <= ctl;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      if (in_fire && emit) widx_r <= widx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    k_r  <= k_nxt;
    l_r  <= l_nxt;
    pi_r <= pi_nxt;
    pj_r <= pj_nxt;
    if (in_fire) begin
      w_r       <= w_c;
      lmax_r    <= lmax_c;
      nch_r     <= nch_c;
      start_r   <= head_nxt - addr_t'(span);
      cur_idx_r <= widx_r;
    end
    if (out_load) begin
      out_data_r <= {3'b000, best[pi_r][pj_r], pj_r, pi_r, cur_idx_r};
      out_last_r <= last_pair;
    end
  end

endmodule
